FILE: rtl/sacl_pkg.sv
// Shared constants for the set-associative tag cache with LRU replacement.
// No dependencies; used by the top level.
package sacl_pkg;

  // Configuration register: log2 of sets in use
  localparam int unsigned CFG_W = 4;
  localparam logic [CFG_W-1:0] SIB_RESET = 4'd10;

  // Result fields
  localparam int unsigned WAY_OUT_W = 4;
  localparam int unsigned COUNT_W   = 48;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Result tdata: hit, way, hit_total, miss_total, padded to bytes
  localparam int unsigned OUT_FIELDS_W = 1 + WAY_OUT_W + 2 * COUNT_W;
  localparam int unsigned OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

FILE: rtl/sacl_lookup.sv
// Way lookup for one set row: tag compare, free-way search and LRU victim.
// Purely combinational; no package dependencies.
module sacl_lookup #(
  parameter int unsigned WAYS   = 16,
  parameter int unsigned TAG_W  = 42,
  parameter int unsigned RANK_W = 4
) (
  input  logic [WAYS*TAG_W-1:0]  tags_i,
  input  logic [WAYS-1:0]        valid_i,
  input  logic [WAYS*RANK_W-1:0] ranks_i,
  input  logic [TAG_W-1:0]       tag_i,
  output logic                   hit_o,
  output logic [RANK_W-1:0]      way_o,
  output logic [RANK_W-1:0]      old_rank_o,
  output logic                   was_valid_o
);

  localparam logic [RANK_W-1:0] OLDEST = RANK_W'(WAYS - 1);

  logic [WAYS-1:0]   eq;
  logic [RANK_W-1:0] hit_way;
  logic [RANK_W-1:0] free_way;
  logic [RANK_W-1:0] lru_way;
  logic              free_any;

  // Per-way compares, priority picks lowest-numbered way (scan from the top)
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      eq[w] = valid_i[w] && (tags_i[w*TAG_W +: TAG_W] == tag_i);
      if (eq[w]) begin
        hit_way = RANK_W'(w);
      end
      if (!valid_i[w]) begin
        free_way = RANK_W'(w);
      end
      // full set: ranks are a permutation, oldest holds WAYS-1
      if (ranks_i[w*RANK_W +: RANK_W] == OLDEST) begin
        lru_way = RANK_W'(w);
      end
    end
  end

  assign hit_o    = |eq;
  assign free_any = ~&valid_i;

  // Selected way and its state before the update
  always_comb begin
    if (hit_o) begin
      way_o = hit_way;
    end else if (free_any) begin
      way_o = free_way;
    end else begin
      way_o = lru_way;
    end
  end

  assign was_valid_o = hit_o || !free_any;
  assign old_rank_o  = ranks_i[way_o*RANK_W +: RANK_W];

endmodule

FILE: rtl/set_assoc_cache_tag_lru_top.sv
// Set-associative tag cache with exact LRU replacement, hit and miss counters.
// Each address passes through row read, lookup and write-back, with registers after the row read and the lookup.
// A new address is taken only once the previous one has been written back, because of the
// row read/modify/write of the tag and meta memories; a result waits in an output register.
// Reset: a clearing pass over all 2**MAX_SET_INDEX_BITS sets zeroes valid and rank
// rows; no input is taken until it ends.
module set_assoc_cache_tag_lru_top #(
  parameter int unsigned WAYS               = 16,
  parameter int unsigned BLOCK_OFFSET_BITS  = 6,
  parameter int unsigned MAX_SET_INDEX_BITS = 10,
  parameter int unsigned ADDR_BITS          = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration: set_index_bits
  input  logic                           cfg_we_i,
  input  logic [sacl_pkg::CFG_W-1:0]     cfg_wdata_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [((ADDR_BITS+7)/8)*8-1:0] s_axis_tdata,  // addr
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sacl_pkg::OUT_W-1:0]     m_axis_tdata   // hit, way, hit_total, miss_total
);

  localparam int unsigned TAG_W    = ADDR_BITS - BLOCK_OFFSET_BITS;
  localparam int unsigned SET_W    = (MAX_SET_INDEX_BITS > 0) ? MAX_SET_INDEX_BITS : 1;
  localparam int unsigned NUM_SETS = 1 << MAX_SET_INDEX_BITS;
  localparam int unsigned RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned META_W   = WAYS + WAYS * RANK_W;
  localparam int unsigned CW       = sacl_pkg::COUNT_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [SET_W-1:0] clr_q;
  logic [sacl_pkg::CFG_W-1:0] cfg_q;
  logic [sacl_pkg::CFG_W-1:0] sib;

  logic [ADDR_BITS-1:0]   addr;
  logic [TAG_W-1:0]       blk;
  logic [TAG_W+SET_W-1:0] blk_ext;
  logic [SET_W-1:0]       set_mask;
  logic [SET_W-1:0]       set_in;
  logic [TAG_W-1:0]       tag_in;
  logic [SET_W-1:0]       set_q;
  logic [TAG_W-1:0]       tag_q;
  logic                   accept;

  // memories: tag rows (no reset) and valid/rank rows (cleared after reset)
  logic [WAYS*TAG_W-1:0] tag_mem [NUM_SETS];
  logic [META_W-1:0]     meta_mem [NUM_SETS];
  logic [WAYS*TAG_W-1:0] tag_rdata_q;
  logic [META_W-1:0]     meta_rdata_q;
  logic                  meta_we;
  logic [SET_W-1:0]      meta_waddr;
  logic [META_W-1:0]     meta_wdata;
  logic                  tag_we;
  logic [WAYS*TAG_W-1:0] tag_wdata;

  logic [WAYS-1:0]        row_valid;
  logic [WAYS*RANK_W-1:0] row_ranks;

  logic              lk_hit, lk_was_valid;
  logic [RANK_W-1:0] lk_way, lk_old_rank;
  logic              hit_q, was_valid_q;
  logic [RANK_W-1:0] way_q, old_rank_q;

  logic [WAYS-1:0]        new_valid;
  logic [WAYS*RANK_W-1:0] new_ranks;
  logic [CW-1:0]          hit_cnt_q, miss_cnt_q, hit_cnt_d, miss_cnt_d;
  logic                   out_free, do_write;
  logic [RANK_W+sacl_pkg::WAY_OUT_W-1:0] way_ext;
  logic                   m_vld_q;
  logic [sacl_pkg::OUT_W-1:0] m_data_q;

  // Clamp register, split address into set and tag
  assign sib = (cfg_q > sacl_pkg::CFG_W'(MAX_SET_INDEX_BITS))
             ? sacl_pkg::CFG_W'(MAX_SET_INDEX_BITS) : cfg_q;
  assign addr    = s_axis_tdata[ADDR_BITS-1:0];
  assign blk     = addr[ADDR_BITS-1:BLOCK_OFFSET_BITS];
  assign blk_ext = {{SET_W{1'b0}}, blk};
  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (sacl_pkg::CFG_W'(i) < sib);
    end
  end
  assign set_in = blk_ext[SET_W-1:0] & set_mask;
  assign tag_in = blk >> sib;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= sacl_pkg::SIB_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Row memories, registered read
  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (tag_we) begin
      tag_mem[set_q] <= tag_wdata;
    end
    if (accept) begin
      meta_rdata_q <= meta_mem[set_in];
      tag_rdata_q  <= tag_mem[set_in];
    end
  end

  assign row_valid = meta_rdata_q[WAYS-1:0];
  assign row_ranks = meta_rdata_q[META_W-1:WAYS];

  sacl_lookup #(
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .RANK_W (RANK_W)
  ) u_lookup (
    .tags_i      (tag_rdata_q),
    .valid_i     (row_valid),
    .ranks_i     (row_ranks),
    .tag_i       (tag_q),
    .hit_o       (lk_hit),
    .way_o       (lk_way),
    .old_rank_o  (lk_old_rank),
    .was_valid_o (lk_was_valid)
  );

  // Rank aging and fill of the selected way
  always_comb begin
    for (int v = 0; v < WAYS; v++) begin
      new_valid[v] = row_valid[v] || (RANK_W'(v) == way_q);
      if (RANK_W'(v) == way_q) begin
        new_ranks[v*RANK_W +: RANK_W] = '0;
      end else if (row_valid[v] &&
                   (!was_valid_q || (row_ranks[v*RANK_W +: RANK_W] < old_rank_q))) begin
        new_ranks[v*RANK_W +: RANK_W] = RANK_W'(row_ranks[v*RANK_W +: RANK_W] + 1'b1);
      end else begin
        new_ranks[v*RANK_W +: RANK_W] = row_ranks[v*RANK_W +: RANK_W];
      end
    end
    tag_wdata = tag_rdata_q;
    tag_wdata[way_q*TAG_W +: TAG_W] = tag_q;
  end

  assign out_free = !m_vld_q || m_axis_tready;
  assign do_write = (state_q == ST_WRITE) && out_free;

  // Write port: clearing pass or write-back
  always_comb begin
    if (state_q == ST_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_q;
      meta_wdata = '0;
    end else begin
      meta_we    = do_write;
      meta_waddr = set_q;
      meta_wdata = {new_ranks, new_valid};
    end
  end
  assign tag_we = do_write && !hit_q;

  // Saturating counters
  always_comb begin
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (hit_q) begin
      if (hit_cnt_q != sacl_pkg::COUNT_MAX) begin
        hit_cnt_d = hit_cnt_q + 1'b1;
      end
    end else begin
      if (miss_cnt_q != sacl_pkg::COUNT_MAX) begin
        miss_cnt_d = miss_cnt_q + 1'b1;
      end
    end
  end

  assign way_ext = {{sacl_pkg::WAY_OUT_W{1'b0}}, way_q};

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == SET_W'(NUM_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= SET_W'(clr_q + 1'b1);
      end
      if (do_write) begin
        hit_cnt_q  <= hit_cnt_d;
        miss_cnt_q <= miss_cnt_d;
        m_vld_q    <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= set_in;
      tag_q <= tag_in;
    end
    if (state_q == ST_LOOK) begin
      hit_q       <= lk_hit;
      way_q       <= lk_way;
      old_rank_q  <= lk_old_rank;
      was_valid_q <= lk_was_valid;
    end
    if (do_write) begin
      m_data_q <= sacl_pkg::OUT_W'({miss_cnt_d, hit_cnt_d,
                                    way_ext[sacl_pkg::WAY_OUT_W-1:0], hit_q});
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: bench/tb.sv
// Testbench for the set-associative tag cache with LRU replacement.
// Depends on sacl_pkg and set_assoc_cache_tag_lru_top; predicts every lookup
// in a local cache image and checks each result transaction field by field.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned NUM_WAYS    = 16;
  localparam int unsigned OFFSET_BITS = 6;
  localparam int unsigned MAX_SIB     = 10;
  localparam int unsigned NUM_SETS    = 1 << MAX_SIB;
  localparam int unsigned TAG_W       = ADDR_W - OFFSET_BITS;
  localparam int unsigned PHASE_ITEMS = 60;

  typedef struct packed {
    logic                           hit;
    logic [sacl_pkg::WAY_OUT_W-1:0] way;
    logic [sacl_pkg::COUNT_W-1:0]   hit_total;
    logic [sacl_pkg::COUNT_W-1:0]   miss_total;
  } access_result_t;

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [sacl_pkg::CFG_W-1:0]     cfg_wdata_i   = sacl_pkg::SIB_RESET;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [ADDR_W-1:0]              s_axis_tdata  = '0;  // addr
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [sacl_pkg::OUT_W-1:0]     m_axis_tdata;  // hit, way, hit_total, miss_total

  // Cache image kept by the predictor
  logic [TAG_W-1:0]             line_tag   [NUM_SETS][NUM_WAYS];
  bit                           line_valid [NUM_SETS][NUM_WAYS];
  int                           line_rank  [NUM_SETS][NUM_WAYS];
  logic [sacl_pkg::COUNT_W-1:0] hit_count  = '0;
  logic [sacl_pkg::COUNT_W-1:0] miss_count = '0;
  logic [sacl_pkg::CFG_W-1:0]   sib_cfg    = sacl_pkg::SIB_RESET;

  access_result_t    pending_results[$];
  logic [ADDR_W-1:0] recent_addrs[$];
  logic [ADDR_W-1:0] last_addr    = '0;
  bit                send_idle_on = 1'b1;
  bit                recv_idle_on = 1'b1;
  int                err_count    = 0;
  int                n_sent       = 0;
  int                n_checked    = 0;
  int                n_settings   = 1;

  set_assoc_cache_tag_lru_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Safety net against a hung handshake
  initial begin
    #3_600_000;
    $display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned sets_in_use_log2();
    return (int'(sib_cfg) > MAX_SIB) ? MAX_SIB : int'(sib_cfg);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Make way w the most recent; valid ways younger than it (all, if it was invalid) age by one
  function automatic void promote_way(int unsigned set_idx, int w);
    bit was_valid;
    int old_rank;
    was_valid = line_valid[set_idx][w];
    old_rank  = line_rank[set_idx][w];
    for (int v = 0; v < NUM_WAYS; v++)
      if (v != w && line_valid[set_idx][v] && (!was_valid || line_rank[set_idx][v] < old_rank))
        line_rank[set_idx][v]++;
    line_rank[set_idx][w] = 0;
  endfunction

  // Look the address up in the image, update it and return the expected result
  function automatic access_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
    int unsigned       sib;
    int unsigned       set_idx;
    int                found;
    int                victim;
    logic [ADDR_W-1:0] tag_val;
    access_result_t    res;
    sib     = sets_in_use_log2();
    set_idx = 32'((addr >> OFFSET_BITS) & ADDR_W'((1 << sib) - 1));
    tag_val = addr >> (OFFSET_BITS + sib);
    found   = -1;
    for (int w = 0; w < NUM_WAYS; w++)
      if (found < 0 && line_valid[set_idx][w] && line_tag[set_idx][w] == tag_val[TAG_W-1:0])
        found = w;
    res.hit = (found >= 0);
    if (res.hit) begin
      promote_way(set_idx, found);
      if (hit_count != sacl_pkg::COUNT_MAX) hit_count++;
    end else begin
      // lowest invalid way, else the oldest (lowest number on a tie)
      victim = -1;
      for (int w = 0; w < NUM_WAYS; w++)
        if (victim < 0 && !line_valid[set_idx][w]) victim = w;
      if (victim < 0) begin
        victim = 0;
        for (int w = 1; w < NUM_WAYS; w++)
          if (line_rank[set_idx][w] > line_rank[set_idx][victim]) victim = w;
      end
      promote_way(set_idx, victim);
      line_tag[set_idx][victim]   = tag_val[TAG_W-1:0];
      line_valid[set_idx][victim] = 1'b1;
      found = victim;
      if (miss_count != sacl_pkg::COUNT_MAX) miss_count++;
    end
    res.way        = sacl_pkg::WAY_OUT_W'(found);
    res.hit_total  = hit_count;
    res.miss_total = miss_count;
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] compose_addr(int unsigned sib, int unsigned set_idx,
                                                     logic [ADDR_W-1:0] tag_val);
    return (tag_val << (OFFSET_BITS + sib)) | (ADDR_W'(set_idx) << OFFSET_BITS) |
           ADDR_W'($urandom_range(0, 63));
  endfunction

  // One address transaction; tvalid stays high across back-to-back sends
  task automatic send_addr(input logic [ADDR_W-1:0] addr);
    int gap;
    gap = send_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_lookup(addr));
    recent_addrs.push_back(addr);
    if (recent_addrs.size() > 32) void'(recent_addrs.pop_front());
    last_addr = addr;
    n_sent++;
  endtask

  // Drop tvalid, wait for all results, then let the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_sib(input logic [sacl_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sib_cfg = value;
    n_settings++;
  endtask

  // Result side: random stalls, with stall-free stretches
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (recv_idle_on && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    access_result_t exp_res;
    access_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit        = m_axis_tdata[0];
      got.way        = m_axis_tdata[1 +: sacl_pkg::WAY_OUT_W];
      got.hit_total  = m_axis_tdata[1 + sacl_pkg::WAY_OUT_W +: sacl_pkg::COUNT_W];
      got.miss_total = m_axis_tdata[1 + sacl_pkg::WAY_OUT_W + sacl_pkg::COUNT_W +:
                                    sacl_pkg::COUNT_W];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (got.hit != exp_res.hit) begin
          $display("%0t: hit expected %0d got %0d", $time, exp_res.hit, got.hit);
          err_count++;
        end
        if (got.way != exp_res.way) begin
          $display("%0t: way expected %0d got %0d", $time, exp_res.way, got.way);
          err_count++;
        end
        if (got.hit_total != exp_res.hit_total) begin
          $display("%0t: hit_total expected %0d got %0d", $time, exp_res.hit_total,
                   got.hit_total);
          err_count++;
        end
        if (got.miss_total != exp_res.miss_total) begin
          $display("%0t: miss_total expected %0d got %0d", $time, exp_res.miss_total,
                   got.miss_total);
          err_count++;
        end
      end
    end
  end

  // Address extremes at the reset split: zero, all ones, offset-only change
  task automatic test_extremes();
    send_addr('0);
    send_addr(ADDR_W'(6'h3f));
    send_addr('1);
    send_addr({{(ADDR_W-OFFSET_BITS){1'b1}}, {OFFSET_BITS{1'b0}}});
    send_addr(ADDR_W'(20'h1_0000));
    send_addr({1'b1, {(ADDR_W-1){1'b0}}});
  endtask

  // One set only: fill all ways, keep one young, then evict the oldest.
  // Old contents are reread under the new split.
  task automatic test_lru_eviction();
    write_sib('0);
    send_addr(ADDR_W'(0));
    for (int t = 1; t <= 17; t++) send_addr(compose_addr(0, 0, ADDR_W'(t)));
    send_addr(compose_addr(0, 0, ADDR_W'(5)));
    send_addr(compose_addr(0, 0, ADDR_W'(40)));
    send_addr(compose_addr(0, 0, ADDR_W'(41)));
  endtask

  // Random lookups under one register setting: reuse, hot-set thrashing,
  // wide random addresses and back-to-back same-set traffic
  task automatic test_random_phase(input logic [sacl_pkg::CFG_W-1:0] sib_value);
    int unsigned       sib;
    int unsigned       set_mask;
    int unsigned       hot_a;
    int unsigned       hot_b;
    int                pick;
    logic [ADDR_W-1:0] tag_base;
    logic [ADDR_W-1:0] addr;
    write_sib(sib_value);
    sib      = sets_in_use_log2();
    set_mask = (1 << sib) - 1;
    hot_a    = $urandom & set_mask;
    hot_b    = $urandom & set_mask;
    tag_base = ADDR_W'({$urandom, $urandom});
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 20 == 0) begin
        send_idle_on = ($urandom_range(0, 3) != 0);
        recv_idle_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35 && recent_addrs.size() > 0) begin
        addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
        addr[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom);
      end else if (pick < 70) begin
        addr = compose_addr(sib, $urandom_range(0, 1) ? hot_a : hot_b,
                            tag_base + ADDR_W'($urandom_range(0, 19)));
      end else if (pick < 85) begin
        addr = ADDR_W'({$urandom, $urandom});
      end else begin
        addr = compose_addr(sib, 32'((last_addr >> OFFSET_BITS) & ADDR_W'(set_mask)),
                            ADDR_W'({$urandom, $urandom}));
      end
      send_addr(addr);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_lru_eviction();
    test_random_phase(4'd10);
    test_random_phase(4'd0);
    test_random_phase(4'd15);
    test_random_phase(4'd4);
    test_random_phase(4'd1);
    test_random_phase(4'd12);
    test_random_phase(4'd7);
    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Looked up %0d addresses (%0d results checked) over %0d register settings,",
             n_sent, n_checked, n_settings);
    $display("with %0d hits and %0d misses in the predicted cache.", hit_count, miss_count);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sacl_pkg.sv
rtl/sacl_lookup.sv
rtl/set_assoc_cache_tag_lru_top.sv
bench/tb.sv
